FILE: rtl/core/wsp_pkg.sv
// wsp_pkg: types and constants for the RIFF/WAVE stream parser.
// No dependencies; used by every file in rtl/core except wsp_stream_if.
package wsp_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_END     = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_HDR   = 4'd3,
        PH_FMT   = 4'd4,
        PH_SKIP  = 4'd5,
        PH_PAD   = 4'd6,
        PH_DATA  = 4'd7,
        PH_DONE  = 4'd8,
        PH_HALT  = 4'd9
    } phase_t;

    localparam logic [4:0] ERR_NOT_RIFF   = 5'd1;
    localparam logic [4:0] ERR_RSIZE      = 5'd2;
    localparam logic [4:0] ERR_NOT_WAVE   = 5'd3;
    localparam logic [4:0] ERR_HDR_ROOM   = 5'd4;
    localparam logic [4:0] ERR_TRUNC      = 5'd5;
    localparam logic [4:0] ERR_FMT_SHORT  = 5'd6;
    localparam logic [4:0] ERR_EXT_SHORT  = 5'd7;
    localparam logic [4:0] ERR_EXT_SIZE   = 5'd8;
    localparam logic [4:0] ERR_GUID       = 5'd9;
    localparam logic [4:0] ERR_NO_FMT_DAT = 5'd10;
    localparam logic [4:0] ERR_CHANNELS   = 5'd11;
    localparam logic [4:0] ERR_RATE       = 5'd12;
    localparam logic [4:0] ERR_SAMPLE_FMT = 5'd13;
    localparam logic [4:0] ERR_ALIGN      = 5'd14;
    localparam logic [4:0] ERR_DATA_SIZE  = 5'd15;
    localparam logic [4:0] ERR_NO_FMT     = 5'd16;
    localparam logic [4:0] ERR_NO_DATA    = 5'd17;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hfffe;
    localparam logic [31:0] RATE_16K = 32'd16000;
    localparam logic [31:0] RATE_48K = 32'd48000;

    // work item from front to back: a raw byte, an end mark, or a restart
    typedef struct packed {
        logic       restart;
        logic       fin;
        logic [7:0] data;
    } wsp_req_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] sample_bits;
        logic        channel;
        logic        last;
        logic [4:0]  error_code;
        logic [1:0]  channel_count;
        logic        rate_48k;
        logic        float_source;
    } wsp_res_t;

    // GUID tail bytes 25..39 of the extensible fmt chunk
    function automatic logic [7:0] guid_tail(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd5:  v = 8'h10;
            4'd7:  v = 8'h80;
            4'd10: v = 8'haa;
            4'd12: v = 8'h38;
            4'd13: v = 8'h9b;
            4'd14: v = 8'h71;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // exact float32 of s/32768 for a 16-bit signed sample
    function automatic logic [31:0] pcm16_to_f32(input logic [15:0] s);
        logic        sg;
        logic [15:0] mag;
        logic [4:0]  msb;
        logic [15:0] norm;
        logic [7:0]  ex;
        sg  = s[15];
        mag = sg ? (~s + 16'd1) : s;
        msb = 5'd0;
        for (int i = 0; i < 16; i++)
            if (mag[i]) msb = 5'(i);
        norm = mag << (5'd15 - msb);
        ex   = 8'(8'd112 + {3'd0, msb});
        if (mag == 16'd0)
            return 32'd0;
        return {sg, ex, norm[14:0], 8'd0};
    endfunction

endpackage

FILE: rtl/core/wsp_stream_if.sv
// wsp_stream_if: valid/ready channel carrying one payload.
// No dependencies.
interface wsp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/wsp_front.sv
// wsp_front: accepts input requests, drops mode 3, queues the other requests in a 2-entry FIFO.
// Depends on wsp_pkg.
module wsp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_mode,
    input  logic [7:0]      in_byte,
    output logic            q_valid,
    input  logic            q_ready,
    output wsp_pkg::wsp_req_t q_req
);
    import wsp_pkg::*;

    wsp_req_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;
    wsp_req_t   item;

    assign in_ready = count_reg != 2'd2;
    assign item.restart = in_mode == MODE_RESTART;
    assign item.fin     = in_mode == MODE_END;
    assign item.data    = in_byte;
    assign push  = in_valid && in_ready && in_mode != MODE_NONE;
    assign q_valid = count_reg != 2'd0;
    assign q_req   = mem_reg[rd_ptr_reg];
    assign pop   = q_valid && q_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= 2'(count_reg + {1'b0, push} - {1'b0, pop});
        end
    end
endmodule

FILE: rtl/core/wsp_back.sv
// wsp_back: parser state machine and output register.
// Depends on wsp_pkg.
module wsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  wsp_pkg::wsp_req_t q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output wsp_pkg::wsp_res_t out_res
);
    import wsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  fbc_reg, fbc_next;
    logic [31:0] riff_reg, riff_next, chunk_reg, chunk_next;
    logic [31:0] tag_reg, tag_next, sh_reg, sh_next;
    logic        odd_reg, odd_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [1:0]  ekind_reg, ekind_next;
    logic [15:0] chw_reg, chw_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] align_reg, align_next, bits_reg, bits_next, vbits_reg, vbits_next;
    logic [1:0]  guid_reg, guid_next;
    logic        hfmt_reg, hfmt_next, nch_reg, nch_next;
    logic        ov_reg;
    wsp_res_t    res_reg, res;
    logic        emit, step;

    // data-size residue per alignment (align is 2,4 or 8 when checked)
    logic [15:0] w16;
    logic [32:0] padded, riff8;
    logic [5:0]  k;
    logic [7:0]  b;
    logic        pcm_ok, flt_ok;
    logic [15:0] want_align;
    logic [31:0] csz_m1;

    assign q_ready   = !ov_reg || out_ready;
    assign step      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    // next-state logic
    always_comb
    begin
        phase_next = phase_reg; fbc_next = fbc_reg; riff_next = riff_reg;
        chunk_next = chunk_reg; tag_next = tag_reg; sh_next = sh_reg;
        odd_next = odd_reg; ftag_next = ftag_reg; ekind_next = ekind_reg;
        chw_next = chw_reg; rate_next = rate_reg; align_next = align_reg;
        bits_next = bits_reg; vbits_next = vbits_reg; guid_next = guid_reg;
        hfmt_next = hfmt_reg; nch_next = nch_reg;
        emit = 1'b0;
        res  = '0;
        b = q_req.data;
        k = fbc_reg;
        sh_next = {b, sh_reg[31:8]};
        w16 = sh_next[31:16];
        padded = {1'b0, sh_next} + {32'd0, sh_next[0]};
        riff8 = {1'b0, riff_reg} - 33'd8;
        pcm_ok = ekind_reg == 2'd1 && bits_reg == 16'd16 && vbits_reg == 16'd16;
        flt_ok = ekind_reg == 2'd2 && bits_reg == 16'd32 && vbits_reg == 16'd32;
        want_align = 16'(chw_reg * {3'd0, bits_reg[15:3]});
        csz_m1 = chunk_reg - 32'd1;
        if (q_req.restart)
        begin
            phase_next = PH_RIFF; fbc_next = '0; riff_next = '0; chunk_next = '0;
            tag_next = '0; sh_next = '0; odd_next = 1'b0; ftag_next = '0;
            ekind_next = '0; chw_next = '0; rate_next = '0; align_next = '0;
            bits_next = '0; vbits_next = '0; guid_next = 2'b11; hfmt_next = 1'b0;
            nch_next = 1'b0;
        end
        else if (phase_reg == PH_DONE || phase_reg == PH_HALT)
            sh_next = sh_reg;
        else if (q_req.fin)
        begin
            sh_next = sh_reg;
            emit = 1'b1; res.error_code = ERR_TRUNC;
        end
        else
        begin
            unique case (phase_reg)
                PH_RIFF, PH_WAVE:
                begin
                    tag_next = sh_next;
                    fbc_next = 6'(fbc_reg + 6'd1);
                    if (fbc_next == 6'd4)
                    begin
                        fbc_next = '0;
                        if (phase_reg == PH_RIFF)
                        begin
                            if (sh_next != TAG_RIFF)
                            begin
                                emit = 1'b1; res.error_code = ERR_NOT_RIFF;
                            end
                            else phase_next = PH_RSIZE;
                        end
                        else if (sh_next != TAG_WAVE)
                        begin
                            emit = 1'b1; res.error_code = ERR_NOT_WAVE;
                        end
                        else if (riff_reg == 32'd0)
                        begin
                            emit = 1'b1; res.error_code = ERR_NO_FMT;
                        end
                        else if (riff_reg < 32'd8)
                        begin
                            emit = 1'b1; res.error_code = ERR_HDR_ROOM;
                        end
                        else phase_next = PH_HDR;
                    end
                end
                PH_RSIZE:
                begin
                    fbc_next = 6'(fbc_reg + 6'd1);
                    if (fbc_next == 6'd4)
                    begin
                        fbc_next = '0;
                        if (sh_next < 32'd4)
                        begin
                            emit = 1'b1; res.error_code = ERR_RSIZE;
                        end
                        else
                        begin
                            riff_next = sh_next - 32'd4;
                            phase_next = PH_WAVE;
                        end
                    end
                end
                PH_HDR:
                begin
                    if (fbc_reg < 6'd4) tag_next = sh_next;
                    fbc_next = 6'(fbc_reg + 6'd1);
                    if (fbc_next == 6'd8)
                    begin
                        riff_next = riff8[31:0];
                        if (padded > riff8)
                        begin
                            emit = 1'b1; res.error_code = ERR_TRUNC;
                        end
                        else
                        begin
                            riff_next = 32'(riff8 - padded);
                            odd_next = sh_next[0];
                            chunk_next = sh_next;
                            fbc_next = '0;
                            if (tag_reg == TAG_FMT)
                            begin
                                if (sh_next < 32'd16)
                                begin
                                    emit = 1'b1; res.error_code = ERR_FMT_SHORT;
                                end
                                else phase_next = PH_FMT;
                            end
                            else if (tag_reg == TAG_DATA)
                            begin
                                emit = 1'b1;
                                if (!hfmt_reg) res.error_code = ERR_NO_FMT_DAT;
                                else if (chw_reg != 16'd1 && chw_reg != 16'd2)
                                    res.error_code = ERR_CHANNELS;
                                else if (rate_reg != RATE_16K && rate_reg != RATE_48K)
                                    res.error_code = ERR_RATE;
                                else if (!pcm_ok && !flt_ok)
                                    res.error_code = ERR_SAMPLE_FMT;
                                else if (align_reg != want_align)
                                    res.error_code = ERR_ALIGN;
                                else if ((align_reg == 16'd2 && sh_next[0]) ||
                                         (align_reg == 16'd4 && sh_next[1:0] != 2'd0) ||
                                         (align_reg == 16'd8 && sh_next[2:0] != 3'd0))
                                    res.error_code = ERR_DATA_SIZE;
                                else
                                begin
                                    nch_next = 1'b0;
                                    phase_next = sh_next == 32'd0 ? PH_DONE : PH_DATA;
                                    res.kind = KIND_FORMAT;
                                    res.last = sh_next == 32'd0;
                                    res.channel_count = chw_reg[1:0];
                                    res.rate_48k = rate_reg == RATE_48K;
                                    res.float_source = flt_ok;
                                end
                            end
                            else if (sh_next != 32'd0) phase_next = PH_SKIP;
                            else if (sh_next[0]) phase_next = PH_PAD;
                            else if (riff_next == 32'd0)
                            begin
                                emit = 1'b1;
                                res.error_code = hfmt_reg ? ERR_NO_DATA : ERR_NO_FMT;
                            end
                            else if (riff_next < 32'd8)
                            begin
                                emit = 1'b1; res.error_code = ERR_HDR_ROOM;
                            end
                            else phase_next = PH_HDR;
                        end
                    end
                end
                PH_FMT:
                begin
                    chunk_next = csz_m1;
                    fbc_next = 6'(fbc_reg + 6'd1);
                    if (k == 6'd1)
                    begin
                        ftag_next = w16;
                        ekind_next = w16 == 16'd1 ? 2'd1 : (w16 == 16'd3 ? 2'd2 : 2'd0);
                    end
                    else if (k == 6'd3) chw_next = w16;
                    else if (k == 6'd7) rate_next = sh_next;
                    else if (k == 6'd13) align_next = w16;
                    else if (k == 6'd15 || k == 6'd39)
                    begin
                        if (k == 6'd15)
                        begin
                            bits_next = w16; vbits_next = w16;
                        end
                        else
                        begin
                            if (b != 8'h71) guid_next = 2'b00;
                            else guid_next = guid_reg;
                        end
                        if (k == 6'd15 && ftag_reg == FMT_EXTENSIBLE)
                        begin
                            if (csz_m1 < 32'd24)
                            begin
                                emit = 1'b1; res.error_code = ERR_EXT_SHORT;
                            end
                            guid_next = 2'b11;
                        end
                        else if (k == 6'd39 && guid_next == 2'b00)
                        begin
                            emit = 1'b1; res.error_code = ERR_GUID;
                        end
                        else
                        begin
                            if (k == 6'd39)
                                ekind_next = guid_next[0] ? 2'd1 : 2'd2;
                            hfmt_next = 1'b1;
                            if (csz_m1 != 32'd0) phase_next = PH_SKIP;
                            else if (odd_reg) phase_next = PH_PAD;
                            else if (riff_reg == 32'd0)
                            begin
                                emit = 1'b1; res.error_code = ERR_NO_DATA;
                            end
                            else if (riff_reg < 32'd8)
                            begin
                                emit = 1'b1; res.error_code = ERR_HDR_ROOM;
                            end
                            else
                            begin
                                phase_next = PH_HDR; fbc_next = '0;
                            end
                        end
                    end
                    else if (k == 6'd17)
                    begin
                        if (w16 < 16'd22)
                        begin
                            emit = 1'b1; res.error_code = ERR_EXT_SIZE;
                        end
                    end
                    else if (k == 6'd19) vbits_next = w16;
                    else if (k == 6'd24)
                        guid_next = guid_reg & {b == 8'd3, b == 8'd1};
                    else if (k > 6'd24 && b != guid_tail(4'(k - 6'd25)))
                        guid_next = 2'b00;
                end
                PH_SKIP, PH_PAD:
                begin
                    if (phase_reg == PH_SKIP) chunk_next = csz_m1;
                    else odd_next = 1'b0;
                    if (phase_reg == PH_SKIP && csz_m1 != 32'd0) phase_next = PH_SKIP;
                    else if (phase_reg == PH_SKIP && odd_reg) phase_next = PH_PAD;
                    else if (riff_reg == 32'd0)
                    begin
                        emit = 1'b1;
                        res.error_code = hfmt_reg ? ERR_NO_DATA : ERR_NO_FMT;
                    end
                    else if (riff_reg < 32'd8)
                    begin
                        emit = 1'b1; res.error_code = ERR_HDR_ROOM;
                    end
                    else
                    begin
                        phase_next = PH_HDR; fbc_next = '0;
                    end
                end
                PH_DATA:
                begin
                    chunk_next = csz_m1;
                    fbc_next = 6'(fbc_reg + 6'd1);
                    if (fbc_next == (ekind_reg == 2'd1 ? 6'd2 : 6'd4))
                    begin
                        fbc_next = '0;
                        emit = 1'b1;
                        res.kind = KIND_SAMPLE;
                        res.sample_bits = ekind_reg == 2'd1 ? pcm16_to_f32(w16) : sh_next;
                        res.channel = nch_reg;
                        if (chw_reg == 16'd2) nch_next = ~nch_reg;
                        res.last = csz_m1 == 32'd0;
                        if (csz_m1 == 32'd0) phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        // any error result halts the parser
        if (emit && res.kind == KIND_SAMPLE && res.error_code != 5'd0)
        begin
            res.kind = KIND_ERROR;
            res.last = 1'b1;
            phase_next = PH_HALT;
        end
        // format result counts as emitted
        if (res.kind == KIND_FORMAT) emit = 1'b1;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF; fbc_reg <= '0; riff_reg <= '0; chunk_reg <= '0;
            tag_reg <= '0; sh_reg <= '0; odd_reg <= 1'b0; ftag_reg <= '0;
            ekind_reg <= '0; chw_reg <= '0; rate_reg <= '0; align_reg <= '0;
            bits_reg <= '0; vbits_reg <= '0; guid_reg <= 2'b11; hfmt_reg <= 1'b0;
            nch_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            if (out_ready) ov_reg <= 1'b0;
            if (step)
            begin
                phase_reg <= phase_next; fbc_reg <= fbc_next; riff_reg <= riff_next;
                chunk_reg <= chunk_next; tag_reg <= tag_next; sh_reg <= sh_next;
                odd_reg <= odd_next; ftag_reg <= ftag_next; ekind_reg <= ekind_next;
                chw_reg <= chw_next; rate_reg <= rate_next; align_reg <= align_next;
                bits_reg <= bits_next; vbits_reg <= vbits_next; guid_reg <= guid_next;
                hfmt_reg <= hfmt_next; nch_reg <= nch_next;
                if (emit) ov_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (step && emit)
            res_reg <= res;
    end
endmodule

FILE: rtl/core/wave_stream_parser.sv
// wave_stream_parser: byte-serial RIFF/WAVE parser, one request per cycle unless output is held.
// Path: a request passes through the 2-entry queue, then its result is held
// in the output register until it is accepted.
// Throughput: 1 request per cycle sustained; stalls only when output is held.
// Reset: rst_n asynchronous active low; parser returns to expecting the RIFF tag.
// Depends on wsp_pkg, wsp_stream_if, wsp_front, wsp_back.
module wave_stream_parser (
    input  logic clk,
    input  logic rst_n,
    wsp_stream_if.sink   in_req,
    wsp_stream_if.source out_res
);
    import wsp_pkg::*;

    logic     q_valid, q_ready;
    wsp_req_t q_req;
    wsp_res_t res;
    logic [9:0] in_pl;

    assign in_pl = in_req.payload;
    assign out_res.payload = res;

    wsp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_req.valid), .in_ready(in_req.ready),
        .in_mode(in_pl[9:8]), .in_byte(in_pl[7:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    wsp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(out_res.valid), .out_ready(out_res.ready), .out_res(res)
    );
endmodule

FILE: rtl/core/wsp_checker.sv
// wsp_checker: port-level checks on the parser, bound to the top level.
// Depends on wsp_pkg.
module wsp_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [44:0] out_payload
);
    import wsp_pkg::*;

    // held result stays stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    // errors are always marked last
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload[44:43] == KIND_ERROR |-> out_payload[9])
        else $error("error not last");

    // error code only on errors
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload[44:43] != KIND_ERROR |-> out_payload[8:4] == 5'd0)
        else $error("error code on non-error");
endmodule

bind wave_stream_parser wsp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_res.valid),
    .out_ready(out_res.ready), .out_payload(out_res.payload)
);

FILE: tb/tb_wave_stream_parser.sv
// tb_wave_stream_parser: self-checking bench for the RIFF/WAVE stream parser.
// Depends on wsp_pkg, wsp_stream_if and wave_stream_parser; directed table, then random files.
`timescale 1ns / 100ps

module tb_wave_stream_parser;
    import wsp_pkg::*;

    typedef struct {
        mode_t      m;
        logic [7:0] b;
    } byte_req_t;

    // directed row: typed expectation only for error rows
    typedef struct {
        mode_t      m;
        logic [7:0] b;
        bit         typed;
        logic [4:0] err;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wsp_stream_if #(.payload_t(wsp_req_t)) in_req();
    wsp_stream_if #(.payload_t(wsp_res_t)) out_res();

    wave_stream_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req),
        .out_res (out_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // tail of the KSDATAFORMAT subformat GUID after its first byte
    localparam logic [7:0] SUBFMT_TAIL [15] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10,
        8'h00, 8'h80, 8'h00, 8'h00, 8'haa, 8'h00, 8'h38, 8'h9b, 8'h71};

    // parser shadow state
    phase_t      ph;
    int unsigned fcnt;
    logic [31:0] riff_left, chunk_left, tag_sh, fsh, rate_w;
    logic        odd, have_fmt, next_ch;
    logic [15:0] fmt_tag, ch_w, al_w, bits_w, vbits_w;
    logic [1:0]  eff, gflags;

    byte_req_t   stim_q [$];
    dir_row_t    dir_tab [$];
    bit          typed_q [$];
    logic [4:0]  typed_err_q [$];
    wsp_res_t    expected_res_q [$];
    int          n_accepted = 0;
    bit          calm = 1'b0;
    bit          failed = 1'b0;

    function automatic void shadow_reset();
        ph = PH_RIFF; fcnt = 0; riff_left = '0; chunk_left = '0; tag_sh = '0; fsh = '0;
        odd = 0; fmt_tag = '0; eff = '0; ch_w = '0; rate_w = '0; al_w = '0; bits_w = '0;
        vbits_w = '0; gflags = 2'b11; have_fmt = 0; next_ch = 0;
    endfunction

    // exact float32 pattern of s/32768
    function automatic logic [31:0] pcm_to_float(input logic signed [15:0] s);
        logic [16:0] mag;
        int          p;
        logic [31:0] man;
        if (s == 0)
            return '0;
        mag = s[15] ? 17'(-32'(s)) : 17'(s);
        p = 0;
        for (int i = 0; i < 17; i++)
            if (mag[i]) p = i;
        man = (32'(mag) << (23 - p)) & 32'h007f_ffff;
        return {s[15], 8'(127 + p - 15), man[22:0]};
    endfunction

    function automatic bit raise_err(input logic [4:0] code, output wsp_res_t r);
        ph = PH_HALT;
        r = '0;
        r.kind = KIND_ERROR;
        r.last = 1'b1;
        r.error_code = code;
        return 1;
    endfunction

    function automatic bit at_boundary(output wsp_res_t r);
        r = '0;
        if (riff_left == 0)
            return raise_err(have_fmt ? ERR_NO_DATA : ERR_NO_FMT, r);
        if (riff_left < 8)
            return raise_err(ERR_HDR_ROOM, r);
        ph = PH_HDR;
        fcnt = 0;
        return 0;
    endfunction

    function automatic bit past_body(output wsp_res_t r);
        r = '0;
        if (chunk_left > 0)
        begin
            ph = PH_SKIP;
            return 0;
        end
        if (odd)
        begin
            ph = PH_PAD;
            return 0;
        end
        return at_boundary(r);
    endfunction

    function automatic bit open_data(input logic [31:0] size, output wsp_res_t r);
        bit pcm, flt;
        r = '0;
        if (!have_fmt) return raise_err(ERR_NO_FMT_DAT, r);
        if (ch_w != 1 && ch_w != 2) return raise_err(ERR_CHANNELS, r);
        if (rate_w != RATE_16K && rate_w != RATE_48K) return raise_err(ERR_RATE, r);
        pcm = eff == 1 && bits_w == 16 && vbits_w == 16;
        flt = eff == 2 && bits_w == 32 && vbits_w == 32;
        if (!pcm && !flt) return raise_err(ERR_SAMPLE_FMT, r);
        if (32'(al_w) != ((32'(ch_w) * (32'(bits_w) / 8)) & 32'hffff))
            return raise_err(ERR_ALIGN, r);
        if (al_w == 0 || (size % 32'(al_w)) != 0) return raise_err(ERR_DATA_SIZE, r);
        chunk_left = size;
        fcnt = 0;
        next_ch = 0;
        ph = (size == 0) ? PH_DONE : PH_DATA;
        r.kind = KIND_FORMAT;
        r.last = (size == 0);
        r.channel_count = ch_w[1:0];
        r.rate_48k = (rate_w == RATE_48K);
        r.float_source = flt;
        return 1;
    endfunction

    function automatic bit close_header(input logic [31:0] size, output wsp_res_t r);
        logic [32:0] padded;
        r = '0;
        padded = {1'b0, size} + size[0];
        riff_left = riff_left - 8;
        if (padded > {1'b0, riff_left}) return raise_err(ERR_TRUNC, r);
        riff_left = riff_left - padded[31:0];
        odd = size[0];
        chunk_left = size;
        fcnt = 0;
        if (tag_sh == TAG_FMT)
        begin
            if (size < 16) return raise_err(ERR_FMT_SHORT, r);
            ph = PH_FMT;
            return 0;
        end
        if (tag_sh == TAG_DATA) return open_data(size, r);
        return past_body(r);
    endfunction

    function automatic bit fmt_step(input logic [7:0] b, output wsp_res_t r);
        int unsigned k;
        logic [15:0] w16;
        r = '0;
        k = fcnt;
        w16 = fsh[31:16];
        chunk_left = chunk_left - 1;
        fcnt = (k + 1) & 63;
        case (k)
            1:
            begin
                fmt_tag = w16;
                eff = (w16 == 1) ? 2'd1 : ((w16 == 3) ? 2'd2 : 2'd0);
            end
            3: ch_w = w16;
            7: rate_w = fsh;
            13: al_w = w16;
            15:
            begin
                bits_w = w16;
                vbits_w = w16;
                if (fmt_tag == FMT_EXTENSIBLE)
                begin
                    if (chunk_left + 16 < 40) return raise_err(ERR_EXT_SHORT, r);
                    gflags = 2'b11;
                    return 0;
                end
                have_fmt = 1;
                return past_body(r);
            end
            17: if (w16 < 22) return raise_err(ERR_EXT_SIZE, r);
            19: vbits_w = w16;
            default:
            begin
                if (k >= 24)
                begin
                    if (k == 24)
                    begin
                        if (b != 1) gflags &= 2'b10;
                        if (b != 3) gflags &= 2'b01;
                    end
                    else if (b != SUBFMT_TAIL[(k - 25) % 15])
                        gflags = 2'b00;
                    if (k == 39)
                    begin
                        if (gflags[0]) eff = 2'd1;
                        else if (gflags[1]) eff = 2'd2;
                        else return raise_err(ERR_GUID, r);
                        have_fmt = 1;
                        return past_body(r);
                    end
                end
            end
        endcase
        return 0;
    endfunction

    function automatic bit sample_step(output wsp_res_t r);
        int unsigned need;
        r = '0;
        need = (eff == 1) ? 2 : 4;
        chunk_left = chunk_left - 1;
        fcnt = (fcnt + 1) & 63;
        if (fcnt < need) return 0;
        fcnt = 0;
        r.kind = KIND_SAMPLE;
        r.sample_bits = (need == 2) ? pcm_to_float(fsh[31:16]) : fsh;
        r.channel = next_ch;
        if (ch_w == 2) next_ch = ~next_ch;
        r.last = (chunk_left == 0);
        if (r.last) ph = PH_DONE;
        return 1;
    endfunction

    // advance the shadow parser by one accepted request
    function automatic bit parse_byte(input mode_t m, input logic [7:0] b, output wsp_res_t r);
        r = '0;
        if (m == MODE_RESTART)
        begin
            shadow_reset();
            return 0;
        end
        if (m == MODE_NONE || ph == PH_DONE || ph == PH_HALT) return 0;
        if (m == MODE_END) return raise_err(ERR_TRUNC, r);
        fsh = {b, fsh[31:8]};
        case (ph)
            PH_RIFF, PH_WAVE:
            begin
                tag_sh = fsh;
                fcnt++;
                if (fcnt < 4) return 0;
                fcnt = 0;
                if (ph == PH_RIFF)
                begin
                    if (tag_sh != TAG_RIFF) return raise_err(ERR_NOT_RIFF, r);
                    ph = PH_RSIZE;
                    return 0;
                end
                if (tag_sh != TAG_WAVE) return raise_err(ERR_NOT_WAVE, r);
                return at_boundary(r);
            end
            PH_RSIZE:
            begin
                fcnt++;
                if (fcnt < 4) return 0;
                fcnt = 0;
                if (fsh < 4) return raise_err(ERR_RSIZE, r);
                riff_left = fsh - 4;
                ph = PH_WAVE;
                return 0;
            end
            PH_HDR:
            begin
                if (fcnt < 4) tag_sh = fsh;
                fcnt = (fcnt + 1) & 63;
                if (fcnt < 8) return 0;
                return close_header(fsh, r);
            end
            PH_FMT: return fmt_step(b, r);
            PH_SKIP:
            begin
                chunk_left = chunk_left - 1;
                return past_body(r);
            end
            PH_PAD:
            begin
                odd = 0;
                return at_boundary(r);
            end
            PH_DATA: return sample_step(r);
            default: return 0;
        endcase
    endfunction

    // file builder
    logic [7:0] fbytes [$];

    task automatic put16(input logic [15:0] v);
        fbytes.push_back(v[7:0]);
        fbytes.push_back(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    function automatic logic [7:0] sample_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    // one file: mostly well formed, sometimes damaged
    task automatic queue_file();
        logic [15:0] nch, bits, tag, align;
        logic [31:0] rate, dsize, jsize, riff_sz;
        bit          flt, ext, junk, bad_guid;
        int          nfr, pos, fmt_len;
        fbytes.delete();
        flt = $urandom_range(0, 1);
        ext = ($urandom_range(0, 3) == 0);
        nch = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(1, 2));
        case ($urandom_range(0, 9))
            0: rate = 32'd44100;
            1, 2, 3, 4: rate = RATE_16K;
            default: rate = RATE_48K;
        endcase
        bits = flt ? 16'd32 : 16'd16;
        if ($urandom_range(0, 14) == 0) bits = 16'd24;
        tag = ext ? FMT_EXTENSIBLE : (flt ? 16'd3 : 16'd1);
        align = 16'(nch * (bits / 8));
        if ($urandom_range(0, 14) == 0) align = align + 1;
        nfr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        dsize = 32'(nfr) * 32'(align);
        junk = ($urandom_range(0, 2) == 0);
        jsize = $urandom_range(0, 5);
        bad_guid = ($urandom_range(0, 14) == 0);
        fmt_len = ext ? 40 : 16;
        riff_sz = 4 + 8 + fmt_len + 8 + dsize + dsize[0];
        if (junk) riff_sz += 8 + jsize + jsize[0];
        if ($urandom_range(0, 3) == 0) riff_sz += $urandom_range(0, 4);
        put32(TAG_RIFF);
        put32(riff_sz);
        put32(TAG_WAVE);
        if (junk)
        begin
            put32(32'h4b4e_554a);
            put32(jsize);
            for (int i = 0; i < jsize + jsize[0]; i++) fbytes.push_back(8'($urandom));
        end
        put32(TAG_FMT);
        put32(fmt_len);
        put16(tag);
        put16(nch);
        put32(rate);
        put32(rate * align);
        put16(align);
        put16(bits);
        if (ext)
        begin
            put16(16'd22);
            put16(bits);
            put32(32'h3);
            fbytes.push_back(flt ? 8'h03 : 8'h01);
            for (int i = 0; i < 15; i++) fbytes.push_back(SUBFMT_TAIL[i]);
            if (bad_guid) fbytes[fbytes.size() - 1 - $urandom_range(0, 15)] ^= 8'h5a;
        end
        put32(TAG_DATA);
        put32(dsize);
        for (int i = 0; i < dsize; i++) fbytes.push_back(sample_byte());
        while (fbytes.size() < riff_sz + 8) fbytes.push_back(8'($urandom));
        // damage: overwrite one byte, or cut the file short
        case ($urandom_range(0, 7))
            0:
            begin
                pos = $urandom_range(0, fbytes.size() - 1);
                fbytes[pos] = 8'($urandom);
            end
            1: fbytes = fbytes[0:$urandom_range(0, fbytes.size() - 1)];
            default: ;
        endcase
        stim_q.push_back('{MODE_RESTART, 8'($urandom)});
        foreach (fbytes[i]) stim_q.push_back('{MODE_BYTE, fbytes[i]});
        if ($urandom_range(0, 1)) stim_q.push_back('{MODE_END, 8'($urandom)});
        if ($urandom_range(0, 4) == 0) stim_q.push_back('{MODE_BYTE, 8'($urandom)});
    endtask

    // predict on every accepted request
    always @(posedge clk)
    begin
        wsp_res_t r;
        bit       has_res;
        bit       typed;
        logic [4:0] terr;
        if (rst_n && in_req.valid && in_req.ready)
        begin
            typed = 0;
            terr = '0;
            if (typed_q.size() > 0)
            begin
                typed = typed_q.pop_front();
                terr = typed_err_q.pop_front();
            end
            has_res = parse_byte(in_req.payload.restart ? MODE_RESTART :
                                 (in_req.payload.fin ? MODE_END : MODE_BYTE),
                                 in_req.payload.data, r);
            if (typed)
            begin
                r = '0;
                r.kind = KIND_ERROR;
                r.last = 1'b1;
                r.error_code = terr;
                has_res = 1;
            end
            if (has_res) expected_res_q.push_back(r);
            n_accepted++;
        end
    end

    // compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin
        wsp_res_t e, a;
        if (rst_n && out_res.valid && out_res.ready)
        begin
            a = out_res.payload;
            if (expected_res_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, a);
                failed = 1;
            end
            else
            begin
                e = expected_res_q.pop_front();
                if (a.kind !== e.kind || a.sample_bits !== e.sample_bits
                    || a.channel !== e.channel || a.last !== e.last
                    || a.error_code !== e.error_code || a.channel_count !== e.channel_count
                    || a.rate_48k !== e.rate_48k || a.float_source !== e.float_source)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, a);
                    failed = 1;
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off to back up the block
    initial
    begin
        bit held;
        held = 0;
        out_res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && n_accepted >= 300)
            begin
                out_res.ready <= 1'b0;
                repeat (400) @(posedge clk);
                held = 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
                out_res.ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        in_req.valid = 1'b0;
        in_req.payload = '0;
        shadow_reset();
        dir_tab = '{
            '{MODE_RESTART, 8'h00, 0, 5'd0},
            '{MODE_BYTE, "R", 0, 5'd0}, '{MODE_BYTE, "I", 0, 5'd0},
            '{MODE_BYTE, "F", 0, 5'd0}, '{MODE_BYTE, "X", 1, ERR_NOT_RIFF},
            '{MODE_END, 8'hff, 0, 5'd0},
            '{MODE_RESTART, 8'hff, 0, 5'd0},
            '{MODE_BYTE, "R", 0, 5'd0}, '{MODE_BYTE, "I", 0, 5'd0},
            '{MODE_BYTE, "F", 0, 5'd0}, '{MODE_BYTE, "F", 0, 5'd0},
            '{MODE_BYTE, 8'h03, 0, 5'd0}, '{MODE_BYTE, 8'h00, 0, 5'd0},
            '{MODE_BYTE, 8'h00, 0, 5'd0}, '{MODE_BYTE, 8'h00, 1, ERR_RSIZE},
            '{MODE_RESTART, 8'h00, 0, 5'd0},
            '{MODE_END, 8'h00, 1, ERR_TRUNC},
            '{MODE_RESTART, 8'h00, 0, 5'd0},
            '{MODE_BYTE, "R", 0, 5'd0}, '{MODE_BYTE, "I", 0, 5'd0},
            '{MODE_BYTE, "F", 0, 5'd0}, '{MODE_BYTE, "F", 0, 5'd0},
            '{MODE_BYTE, 8'h04, 0, 5'd0}, '{MODE_BYTE, 8'h00, 0, 5'd0},
            '{MODE_BYTE, 8'h00, 0, 5'd0}, '{MODE_BYTE, 8'h00, 0, 5'd0}
        };
        // empty RIFF ends without a fmt chunk on its WAVE tag
        foreach (dir_tab[i])
        begin
            stim_q.push_back('{dir_tab[i].m, dir_tab[i].b});
            typed_q.push_back(dir_tab[i].typed);
            typed_err_q.push_back(dir_tab[i].err);
        end
        stim_q.push_back('{MODE_BYTE, "W"});
        stim_q.push_back('{MODE_BYTE, "A"});
        stim_q.push_back('{MODE_BYTE, "V"});
        stim_q.push_back('{MODE_BYTE, "E"});
        for (int i = 0; i < 3; i++) typed_q.push_back(0);
        typed_q.push_back(1);
        for (int i = 0; i < 3; i++) typed_err_q.push_back(5'd0);
        typed_err_q.push_back(ERR_NO_FMT);
        while (stim_q.size() < 1550) queue_file();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_q[i])
        begin
            if (i + 200 >= stim_q.size()) calm = 1;
            if (!calm && $urandom_range(0, 6) == 0)
            begin
                in_req.valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            in_req.valid <= 1'b1;
            in_req.payload.restart <= (stim_q[i].m == MODE_RESTART);
            in_req.payload.fin <= (stim_q[i].m == MODE_END);
            in_req.payload.data <= stim_q[i].b;
            do @(posedge clk); while (!in_req.ready);
        end
        in_req.valid <= 1'b0;
        while (expected_res_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed && expected_res_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: wave_stream_parser.f
rtl/core/wsp_pkg.sv
rtl/core/wsp_stream_if.sv
rtl/core/wsp_front.sv
rtl/core/wsp_back.sv
rtl/core/wave_stream_parser.sv
rtl/core/wsp_checker.sv
tb/tb_wave_stream_parser.sv
